// ===== sv/mts_pkg.sv =====
// Shared types and codes for the min-tracking stack.
package mts_pkg;

  typedef logic [1:0]         req_t;
  typedef logic [1:0]         status_t;
  typedef logic signed [31:0] word_t;
  typedef logic [10:0]        count_out_t;

  localparam req_t REQ_PUSH = 2'd0;
  localparam req_t REQ_POP  = 2'd1;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNDERFLOW = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    word_t min_val;
    word_t value;
  } entry_t;

  typedef struct packed {
    logic    do_push;
    logic    do_pop;
    logic    load_below;
    logic    post;
    status_t status;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic out_hold;
  } dp_stat_t;

endpackage

// ===== sv/mts_ifs.sv =====
// Request and result channel interfaces for the min-tracking stack.
interface mts_req_if;
  logic              valid;
  logic              ready;
  mts_pkg::req_t     req_type;
  mts_pkg::word_t    push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface mts_rsp_if;
  logic                  valid;
  logic                  ready;
  mts_pkg::word_t        top_value;
  mts_pkg::word_t        min_value;
  mts_pkg::count_out_t   entry_count;
  mts_pkg::status_t      status;

  modport source (output valid, output top_value, output min_value,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input top_value, input min_value,
                  input entry_count, input status, output ready);
endinterface

// ===== sv/min_tracking_stack.sv =====
// Top level: min-tracking stack with request and result channels.
// Push, query and rejected requests: result registered in the cycle after the request.
// Pop of a nonempty store: entry memory read registered, then result registered from it.
// Throughput: one request per cycle unless a result is held or a pop is in S_POP.
// A new request is taken while a result waits only if that result leaves the same cycle.
// Synchronous reset empties the store; memory contents are not cleared.
module min_tracking_stack #(
  parameter int STACK_DEPTH = 1024
) (
  input logic      clk,
  input logic      rst_n,
  mts_req_if.sink  in_ch,
  mts_rsp_if.source out_ch
);

  mts_pkg::ctl_cmd_t cmd;
  mts_pkg::dp_stat_t stat;

  mts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .stat        (stat),
    .in_ready    (in_ch.ready),
    .cmd         (cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .push_value      (in_ch.push_value),
    .out_ready       (out_ch.ready),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_top_value   (out_ch.top_value),
    .out_min_value   (out_ch.min_value),
    .out_entry_count (out_ch.entry_count),
    .out_status      (out_ch.status)
  );

endmodule

// ===== sv/mts_datapath.sv =====
// Datapath: top and minimum registers, entry memory, count and result register.
module mts_datapath #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mts_pkg::ctl_cmd_t   cmd,
  input  mts_pkg::word_t      push_value,
  input  logic                out_ready,
  output mts_pkg::dp_stat_t   stat,
  output logic                out_valid,
  output mts_pkg::word_t      out_top_value,
  output mts_pkg::word_t      out_min_value,
  output mts_pkg::count_out_t out_entry_count,
  output mts_pkg::status_t    out_status
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [CNT_W-1:0]    count_r, count_nxt;
  mts_pkg::word_t      top_r, top_nxt;
  mts_pkg::word_t      min_r, min_nxt;
  mts_pkg::entry_t     mem [STACK_DEPTH];
  mts_pkg::entry_t     rd_data_r;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                empty;
  logic                full;

  logic                out_valid_r, out_valid_nxt;
  mts_pkg::word_t      out_top_r;
  mts_pkg::word_t      out_min_r;
  mts_pkg::count_out_t out_cnt_r;
  mts_pkg::status_t    out_status_r;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(STACK_DEPTH));
  assign wr_addr = ADDR_W'(count_r - CNT_W'(1));
  assign rd_addr = ADDR_W'(count_r - CNT_W'(2));

  assign stat.empty    = empty;
  assign stat.full     = full;
  assign stat.out_hold = out_valid_r && !out_ready;

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    min_nxt   = min_r;
    if (cmd.do_push) begin
      top_nxt   = push_value;
      min_nxt   = (!empty && (min_r < push_value)) ? min_r : push_value;
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.load_below) begin
      top_nxt   = rd_data_r.value;
      min_nxt   = rd_data_r.min_val;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_push && !empty) begin
      mem[wr_addr] <= '{min_val: min_r, value: top_r};
    end
    if (cmd.do_pop) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    min_r <= min_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.post) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_top_r    <= (count_nxt == '0) ? '0 : top_nxt;
      out_min_r    <= (count_nxt == '0) ? '0 : min_nxt;
      out_cnt_r    <= mts_pkg::count_out_t'(count_nxt);
      out_status_r <= cmd.status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_min_value   = out_min_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_status_r;

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_push |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not advance count");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_below |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not drop count");

  a_no_post_over_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> !(out_valid_r && !out_ready))
    else $error("result posted over an untaken result");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_push |-> !full)
    else $error("push issued on full store");

endmodule

// ===== sv/mts_ctrl.sv =====
// Controller: request decode and pop read sequencing.
module mts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  mts_pkg::req_t     in_req_type,
  input  mts_pkg::dp_stat_t stat,
  output logic              in_ready,
  output mts_pkg::ctl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign in_ready = (state_r == S_IDLE) && !stat.out_hold;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd.do_push    = 1'b0;
    cmd.do_pop     = 1'b0;
    cmd.load_below = 1'b0;
    cmd.post       = 1'b0;
    cmd.status     = mts_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            mts_pkg::REQ_PUSH: begin
              cmd.post = 1'b1;
              if (stat.full) begin
                cmd.status = mts_pkg::ST_OVERFLOW;
              end else begin
                cmd.do_push = 1'b1;
              end
            end
            mts_pkg::REQ_POP: begin
              if (stat.empty) begin
                cmd.post   = 1'b1;
                cmd.status = mts_pkg::ST_UNDERFLOW;
              end else begin
                cmd.do_pop = 1'b1;
                state_nxt  = S_POP;
              end
            end
            default: begin
              cmd.post = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.load_below = 1'b1;
        cmd.post       = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_pop_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_pop |=> (state_r == S_POP) && cmd.load_below)
    else $error("pop read not followed by load");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> !in_ready)
    else $error("request taken during pop read");

endmodule
